@@ hw/rtl/frh_pkg.sv @@
// Shared types and constants for the frame hitch detector.
package frh_pkg;

  localparam int IN_W       = 24;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;
  localparam int RES_W      = 283;
  localparam int OUT_W      = 288;

  localparam logic [CFG_IDX_W-1:0] REG_HITCH_PCT   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FLOOR_US    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WARMUP_LEN  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DUMP_ENABLE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DUMP_LIMIT  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SUMMARY_PER = 3'd5;

  localparam logic [9:0]  RST_HITCH_PCT   = 10'd60;
  localparam logic [19:0] RST_FLOOR_US    = 20'd2000;
  localparam logic [15:0] RST_WARMUP_LEN  = 16'd240;
  localparam logic        RST_DUMP_ENABLE = 1'b1;
  localparam logic [5:0]  RST_DUMP_LIMIT  = 6'd40;
  localparam logic [23:0] RST_SUMMARY_PER = 24'd1000000;

  typedef struct packed {
    logic [9:0]  hitch_pct;
    logic [19:0] floor_us;
    logic [15:0] warmup_len;
    logic        dump_enable;
    logic [5:0]  dump_limit;
    logic [23:0] summary_period_us;
  } cfg_t;

  typedef struct packed {
    logic load;
    logic step;
  } cell_ctrl_t;

  typedef struct packed {
    logic prod;
    logic decide;
  } judge_ctrl_t;

  // first declared field sits in the highest bits
  typedef struct packed {
    logic [31:0] summary_hitches;
    logic [23:0] summary_worst_us;
    logic [39:0] summary_sum_us;
    logic [31:0] summary_frames;
    logic        summary_due;
    logic [31:0] dump_gap;
    logic [31:0] dump_frame;
    logic        dump_due;
    logic [31:0] frame_number;
    logic [31:0] hitch_total;
    logic        is_hitch;
    logic [23:0] median_us;
  } res_t;

endpackage

@@ hw/rtl/frh_cell.sv @@
// Window cell: holds one sample, ranks it against samples circulating past.
module frh_cell #(
  parameter int SW = 24,
  parameter int RW = 6
) (
  input  logic               clk,
  input  frh_pkg::cell_ctrl_t ctrl,
  input  logic [SW-1:0]      shift_in,
  input  logic               ok_in,
  input  logic [RW-1:0]      k,
  input  logic [SW-1:0]      nb_val,
  input  logic               nb_ok,
  input  logic               nb_wrap,
  output logic [SW-1:0]      own_val,
  output logic [SW-1:0]      circ_val,
  output logic               circ_ok,
  output logic               circ_wrap,
  output logic [SW-1:0]      hit_val
);

  logic          own_ok;
  logic [RW-1:0] rank;
  logic          below;

  // circulating sample sorts before this one (ties broken by age)
  assign below = circ_ok && ((circ_val < own_val) || ((circ_val == own_val) && circ_wrap));

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      own_val   <= shift_in;
      own_ok    <= ok_in;
      circ_val  <= shift_in;
      circ_ok   <= ok_in;
      circ_wrap <= 1'b0;
      rank      <= '0;
    end else if (ctrl.step) begin
      if (below) begin
        rank <= rank + RW'(1);
      end
      circ_val  <= nb_val;
      circ_ok   <= nb_ok;
      circ_wrap <= nb_wrap;
    end
  end

  assign hit_val = (own_ok && (rank == k)) ? own_val : '0;

endmodule

@@ hw/rtl/frh_judge.sv @@
// Hitch decision, dump countdown and period summary state.
module frh_judge #(
  parameter int SW         = 24,
  parameter int DUMP_DELAY = 4
) (
  input  logic                 clk,
  input  logic                 rst,
  input  frh_pkg::judge_ctrl_t ctrl,
  input  frh_pkg::cfg_t        cfg,
  input  logic [SW-1:0]        wall,
  input  logic [SW-1:0]        median,
  input  logic [31:0]          frames_seen,
  output frh_pkg::res_t        res
);

  localparam int PW = SW + 7;
  localparam int PM = SW + 11;
  localparam int MW = ((SW > 20) ? SW : 20) + 1;
  localparam logic [4:0] CD_LOAD = 5'(DUMP_DELAY + 1);

  logic [PW-1:0] pw;
  logic [PM-1:0] pm;
  logic [MW-1:0] msum;

  logic [4:0]    dump_countdown, cd_next;
  logic [31:0]   hitch_count, hc_next;
  logic [5:0]    dumps_done, dd_next;
  logic [31:0]   last_hitch_frame, lh_next;
  logic [31:0]   last_dumped_frame, ld_next;
  logic [31:0]   period_frames, pf_next;
  logic [39:0]   period_sum, ps_next;
  logic [SW-1:0] period_worst, pwst_next;
  logic [31:0]   period_hitches, ph_next;

  logic [31:0]   pf_acc, ph_acc;
  logic [39:0]   ps_acc;
  logic [SW-1:0] pwst_acc;
  logic [4:0]    cd_dec;
  logic          hitch, dump, close;

  always_ff @(posedge clk) begin
    if (ctrl.prod) begin
      pw   <= PW'(wall) * PW'(100);
      pm   <= PM'(median) * PM'(11'd100 + 11'(cfg.hitch_pct));
      msum <= MW'(median) + MW'(cfg.floor_us);
    end
  end

  always_comb begin
    hitch   = 1'b0;
    dump    = 1'b0;
    cd_dec  = dump_countdown - 5'd1;
    cd_next = dump_countdown;
    hc_next = hitch_count;
    dd_next = dumps_done;
    lh_next = last_hitch_frame;
    ld_next = last_dumped_frame;
    res     = '0;

    if (dump_countdown != 5'd0) begin
      cd_next = cd_dec;
      if (cd_dec == 5'd0) begin
        dump           = 1'b1;
        dd_next        = dumps_done + 6'd1;
        ld_next        = last_hitch_frame;
        res.dump_frame = last_hitch_frame;
        res.dump_gap   = (last_dumped_frame != 32'd0) ?
                         (last_hitch_frame - last_dumped_frame) : 32'd0;
      end
    end else if (frames_seen > 32'(cfg.warmup_len)) begin
      if ((median != '0) && (PM'(pw) > pm) && (MW'(wall) > msum)) begin
        hitch   = 1'b1;
        hc_next = hitch_count + 32'd1;
        lh_next = frames_seen - 32'd1;
        if (cfg.dump_enable && (dumps_done < cfg.dump_limit)) begin
          cd_next = CD_LOAD;
        end
      end
    end

    pf_acc   = period_frames + 32'd1;
    ps_acc   = period_sum + 40'(wall);
    pwst_acc = (wall > period_worst) ? wall : period_worst;
    ph_acc   = period_hitches + 32'(hitch);
    close    = (ps_acc >= 40'(cfg.summary_period_us));

    pf_next   = close ? '0 : pf_acc;
    ps_next   = close ? '0 : ps_acc;
    pwst_next = close ? '0 : pwst_acc;
    ph_next   = close ? '0 : ph_acc;

    res.median_us    = 24'(median);
    res.is_hitch     = hitch;
    res.hitch_total  = hc_next;
    res.frame_number = frames_seen - 32'd1;
    res.dump_due     = dump;
    res.summary_due  = close;
    if (close) begin
      res.summary_frames   = pf_acc;
      res.summary_sum_us   = ps_acc;
      res.summary_worst_us = 24'(pwst_acc);
      res.summary_hitches  = ph_acc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dump_countdown    <= '0;
      hitch_count       <= '0;
      dumps_done        <= '0;
      last_hitch_frame  <= '0;
      last_dumped_frame <= '0;
      period_frames     <= '0;
      period_sum        <= '0;
      period_worst      <= '0;
      period_hitches    <= '0;
    end else if (ctrl.decide) begin
      dump_countdown    <= cd_next;
      hitch_count       <= hc_next;
      dumps_done        <= dd_next;
      last_hitch_frame  <= lh_next;
      last_dumped_frame <= ld_next;
      period_frames     <= pf_next;
      period_sum        <= ps_next;
      period_worst      <= pwst_next;
      period_hitches    <= ph_next;
    end
  end

endmodule

@@ hw/rtl/frame_hitch_detector.sv @@
// Frame hitch detector top level: window cell chain, control and ports.
//
// Usage: one frame interval (us) per request on the s_axis channel, one
// result per request on the m_axis channel, in order. Registers are written
// through cfg_wr / cfg_index / cfg_data; the user writes them only while
// the block is idle, and the block itself does not enforce this.
// Each request shifts the sample into a chain of WINDOW cells. Then the
// window contents circulate around the chain so every cell learns its
// rank; the cell whose rank is half the fill is the median. The S_MED,
// S_PROD and S_DECIDE states then register the median, form the products
// and update the hitch, dump and summary state.
// A new request is not taken until the last one is through the rank pass
// and the later states; s_axis_tready is high only between requests.
// The result sits in an output register, so the next request is taken while
// it waits; a stalled m_axis holds the pipeline before the state update.
// Reset (rst, synchronous) clears counters, statistics, handshakes and
// restores register defaults; window samples are not cleared and are only
// read once written.
module frame_hitch_detector #(
  parameter int WINDOW      = 64,
  parameter int DUMP_DELAY  = 4,
  parameter int SAMPLE_BITS = 24
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  logic [frh_pkg::IN_W-1:0]             s_axis_tdata,   // interval_us
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  // median_us, is_hitch, hitch_total, frame_number, dump_due, dump_frame,
  // dump_gap, summary_due, summary_frames, summary_sum_us, summary_worst_us,
  // summary_hitches, zero pad
  output logic [frh_pkg::OUT_W-1:0]            m_axis_tdata,
  input  logic                                 cfg_wr,
  input  logic [frh_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [frh_pkg::CFG_DATA_W-1:0]       cfg_data
);

  localparam int SW = SAMPLE_BITS;
  localparam int HW = $clog2(WINDOW + 1);
  localparam int RW = $clog2(WINDOW);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_RANK   = 5'b00010,
    S_MED    = 5'b00100,
    S_PROD   = 5'b01000,
    S_DECIDE = 5'b10000
  } state_t;

  state_t              state, state_next;
  frh_pkg::cfg_t       cfg;
  logic [31:0]         frames_seen;
  logic [HW-1:0]       have, have_new;
  logic [RW-1:0]       step_cnt;
  logic [SW-1:0]       wall, wall_in;
  logic [SW-1:0]       median, med_or;
  logic [31:0]         fs_inc;
  logic                accept, slot_free;
  frh_pkg::cell_ctrl_t cctrl;
  frh_pkg::judge_ctrl_t jctrl;
  frh_pkg::res_t       res;

  logic [SW-1:0] own_val  [WINDOW];
  logic [SW-1:0] circ_val [WINDOW];
  logic          circ_ok  [WINDOW];
  logic          circ_wrap[WINDOW];
  logic [SW-1:0] hit_val  [WINDOW];

  assign s_axis_tready = (state == S_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign slot_free     = !m_axis_tvalid || m_axis_tready;
  assign wall_in       = SW'(s_axis_tdata);
  assign fs_inc        = frames_seen + 32'd1;
  assign have_new      = (fs_inc < 32'(WINDOW)) ? HW'(fs_inc) : HW'(WINDOW);

  assign cctrl.load   = accept;
  assign cctrl.step   = (state == S_RANK);
  assign jctrl.prod   = (state == S_PROD);
  assign jctrl.decide = (state == S_DECIDE) && slot_free;

  for (genvar i = 0; i < WINDOW; i++) begin : g_cell
    frh_cell #(
      .SW(SW),
      .RW(RW)
    ) u_cell (
      .clk      (clk),
      .ctrl     (cctrl),
      .shift_in ((i == 0) ? wall_in : own_val[(i == 0) ? 0 : i - 1]),
      .ok_in    (have_new > HW'(i)),
      .k        (RW'(have >> 1)),
      .nb_val   (circ_val[(i + 1) % WINDOW]),
      .nb_ok    (circ_ok[(i + 1) % WINDOW]),
      .nb_wrap  ((i == WINDOW - 1) ? 1'b1 : circ_wrap[(i + 1) % WINDOW]),
      .own_val  (own_val[i]),
      .circ_val (circ_val[i]),
      .circ_ok  (circ_ok[i]),
      .circ_wrap(circ_wrap[i]),
      .hit_val  (hit_val[i])
    );
  end

  // at most one cell matches the median rank
  always_comb begin
    med_or = '0;
    for (int i = 0; i < WINDOW; i++) begin
      med_or = med_or | hit_val[i];
    end
  end

  frh_judge #(
    .SW        (SW),
    .DUMP_DELAY(DUMP_DELAY)
  ) u_judge (
    .clk        (clk),
    .rst        (rst),
    .ctrl       (jctrl),
    .cfg        (cfg),
    .wall       (wall),
    .median     (median),
    .frames_seen(frames_seen),
    .res        (res)
  );

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:   if (accept) state_next = S_RANK;
      S_RANK:   if (step_cnt == RW'(WINDOW - 1)) state_next = S_MED;
      S_MED:    state_next = S_PROD;
      S_PROD:   state_next = S_DECIDE;
      S_DECIDE: if (slot_free) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      frames_seen   <= '0;
      have          <= '0;
      step_cnt      <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (accept) begin
        frames_seen <= fs_inc;
        have        <= have_new;
        step_cnt    <= '0;
      end else if (state == S_RANK) begin
        step_cnt <= step_cnt + RW'(1);
      end
      if (jctrl.decide) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      wall <= wall_in;
    end
    if (state == S_MED) begin
      median <= med_or;
    end
    if (jctrl.decide) begin
      m_axis_tdata <= {(frh_pkg::OUT_W - frh_pkg::RES_W)'(0), res};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.hitch_pct         <= frh_pkg::RST_HITCH_PCT;
      cfg.floor_us          <= frh_pkg::RST_FLOOR_US;
      cfg.warmup_len        <= frh_pkg::RST_WARMUP_LEN;
      cfg.dump_enable       <= frh_pkg::RST_DUMP_ENABLE;
      cfg.dump_limit        <= frh_pkg::RST_DUMP_LIMIT;
      cfg.summary_period_us <= frh_pkg::RST_SUMMARY_PER;
    end else if (cfg_wr) begin
      case (cfg_index)
        frh_pkg::REG_HITCH_PCT:   cfg.hitch_pct         <= cfg_data[9:0];
        frh_pkg::REG_FLOOR_US:    cfg.floor_us          <= cfg_data[19:0];
        frh_pkg::REG_WARMUP_LEN:  cfg.warmup_len        <= cfg_data[15:0];
        frh_pkg::REG_DUMP_ENABLE: cfg.dump_enable       <= cfg_data[0];
        frh_pkg::REG_DUMP_LIMIT:  cfg.dump_limit        <= cfg_data[5:0];
        frh_pkg::REG_SUMMARY_PER: cfg.summary_period_us <= cfg_data[23:0];
        default: ;
      endcase
    end
  end

endmodule
